### src/rtsp_pkg.sv
// ============================================================================
// RTCP tuner status parser package
// Shared word types, parse-state record and phase codes.
// ============================================================================
package rtsp_pkg;

    // RTCP packet type of an APP packet.
    localparam logic [7:0] APP_TYPE = 8'd204;

    // Saturation limit of all 16-bit magnitudes.
    localparam logic [15:0] SAT16 = 16'hffff;

    // Parse phases.
    localparam logic [2:0] PH_TAG    = 3'd0;  // looking for ";tuner="
    localparam logic [2:0] PH_COMMA  = 3'd1;  // looking for the comma after the tag
    localparam logic [2:0] PH_VSTART = 3'd2;  // before a value: space, sign or digit
    localparam logic [2:0] PH_NUM    = 3'd3;  // inside a number
    localparam logic [2:0] PH_DONE   = 3'd4;  // parsing finished for this string

    // One input word.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [15:0] signal_strength;
        logic        locked;
        logic [15:0] signal_quality;
        logic        tuner_found;
    } t_out_word;

    // Text parser state.
    typedef struct packed {
        logic [2:0]  tag_match;
        logic [2:0]  phase;
        logic [1:0]  field_index;
        logic [15:0] value_acc;
        logic        value_negative;
        logic        digit_seen;
        logic [15:0] level_value;
        logic        lock_flag;
        logic [15:0] quality_value;
    } t_parse;

endpackage

### src/rtsp_text_parser.sv
// ============================================================================
// RTCP tuner status text parser
// Next-state logic of the ";tuner=" string scanner and the result scaling.
// ============================================================================
module rtsp_text_parser (
    input  rtsp_pkg::t_parse    i_state,
    input  logic [7:0]          i_char,
    input  logic                i_feed,
    input  logic                i_clear,
    output rtsp_pkg::t_parse    o_state,
    output rtsp_pkg::t_out_word o_result
);
    import rtsp_pkg::*;

    function automatic logic [7:0] tag_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h3b;  // ';'
            3'd1:    ch = 8'h74;  // 't'
            3'd2:    ch = 8'h75;  // 'u'
            3'd3:    ch = 8'h6e;  // 'n'
            3'd4:    ch = 8'h65;  // 'e'
            3'd5:    ch = 8'h72;  // 'r'
            3'd6:    ch = 8'h3d;  // '='
            default: ch = 8'h3b;  // index wraps onto the first character
        endcase
        return ch;
    endfunction

    // Store the value just parsed into its field and move to the next field.
    function automatic t_parse commit(input t_parse s);
        t_parse     n;
        logic [15:0] v;
        n = s;
        v = s.value_negative ? 16'd0 : s.value_acc;
        unique case (s.field_index)
            2'd0:    n.level_value = v;
            2'd1:    n.lock_flag = (s.value_acc != 16'd0);
            2'd2:    n.quality_value = v;
            default: ;
        endcase
        n.field_index    = s.field_index + 2'd1;
        n.value_acc      = 16'd0;
        n.value_negative = 1'b0;
        n.digit_seen     = 1'b0;
        return n;
    endfunction

    function automatic t_parse feed_char(input t_parse s, input logic [7:0] c);
        t_parse      n;
        logic        is_digit;
        logic        is_space;
        logic [19:0] t;
        n        = s;
        is_digit = (c >= 8'h30) && (c <= 8'h39);
        is_space = (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
        t        = {1'b0, s.value_acc, 3'b000} + {3'b000, s.value_acc, 1'b0}
                   + {16'd0, c[3:0]};
        if (s.phase >= PH_DONE) begin
            n = s;
        end else if (c == 8'h00) begin
            if (s.phase == PH_NUM && s.digit_seen) begin
                n = commit(s);
            end
            n.phase = PH_DONE;
        end else begin
            unique case (s.phase)
                PH_TAG: begin
                    if (c == tag_char(s.tag_match)) begin
                        if (s.tag_match == 3'd6) begin
                            n.tag_match = 3'd0;
                            n.phase     = PH_COMMA;
                        end else begin
                            n.tag_match = s.tag_match + 3'd1;
                        end
                    end else begin
                        n.tag_match = (c == 8'h3b) ? 3'd1 : 3'd0;
                    end
                end
                PH_COMMA: begin
                    if (c == 8'h2c) begin
                        n.phase       = PH_VSTART;
                        n.field_index = 2'd0;
                    end
                end
                PH_VSTART: begin
                    n.value_acc      = 16'd0;
                    n.value_negative = 1'b0;
                    n.digit_seen     = 1'b0;
                    if (is_space) begin
                        n.phase = PH_VSTART;
                    end else if (c == 8'h2b || c == 8'h2d) begin
                        n.value_negative = (c == 8'h2d);
                        n.phase          = PH_NUM;
                    end else if (is_digit) begin
                        n.value_acc  = {12'd0, c[3:0]};
                        n.digit_seen = 1'b1;
                        n.phase      = PH_NUM;
                    end else begin
                        n.phase = PH_DONE;
                    end
                end
                default: begin
                    if (is_digit) begin
                        n.value_acc  = (t > {4'd0, SAT16}) ? SAT16 : t[15:0];
                        n.digit_seen = 1'b1;
                    end else if (!s.digit_seen) begin
                        n.phase = PH_DONE;
                    end else begin
                        n = commit(s);
                        n.phase = (c == 8'h2c && n.field_index != 2'd3) ?
                                  PH_VSTART : PH_DONE;
                    end
                end
            endcase
        end
        return n;
    endfunction

    t_parse      post;
    t_parse      fin;
    logic [24:0] strength_full;
    logic [28:0] quality_full;

    always_comb begin
        if (i_clear) begin
            post = '0;
        end else if (i_feed) begin
            post = feed_char(i_state, i_char);
        end else begin
            post = i_state;
        end
    end

    assign o_state = post;

    // A number still open at the end of the string is committed for the result.
    assign fin = (post.phase == PH_NUM && post.digit_seen) ? commit(post) : post;

    // level * 257 and quality * 4369 (0x1111) as shift-and-add.
    assign strength_full = {1'b0, fin.level_value, 8'd0} + {9'd0, fin.level_value};
    assign quality_full  = {1'b0, fin.quality_value, 12'd0}
                         + {5'd0, fin.quality_value, 8'd0}
                         + {9'd0, fin.quality_value, 4'd0}
                         + {13'd0, fin.quality_value};

    always_comb begin
        o_result.signal_strength = (strength_full[24:16] != 9'd0) ? SAT16 :
                                   strength_full[15:0];
        o_result.locked          = fin.lock_flag;
        if (!fin.lock_flag) begin
            o_result.signal_quality = 16'd0;
        end else begin
            o_result.signal_quality = (quality_full[28:16] != 13'd0) ? SAT16 :
                                      quality_full[15:0];
        end
        o_result.tuner_found = (fin.phase == PH_VSTART) || (fin.phase == PH_NUM)
                             || (fin.phase == PH_DONE && fin.field_index != 2'd0);
    end

endmodule

### src/rtcp_tuner_status_parser.sv
// ============================================================================
// RTCP tuner status parser
// Walks an RTCP compound datagram byte by byte and reports tuner status.
// ============================================================================
// The block takes one datagram byte per word on the input channel, with
// last_byte marking the final byte, and walks the RTCP packet headers. For
// every APP packet that carries a nonzero-length string it scans the text
// for ";tuner=", skips to the next comma and reads three signed decimals
// (level, lock, quality). When the string ends, at its stated length, at the
// packet end or at the datagram end, one result word is produced: strength
// is level*257, locked is lock nonzero, quality is quality*4369 when locked;
// strength and quality saturate at 65535 and are zero for negative values.
// The block sustains one byte per clock cycle; a byte is held in an input
// register and processed from there, and the byte that closes a string
// writes its result into the output register. Input is stalled only when a
// byte that closes a string finds the output register still occupied by a
// result that is being stalled.
// ============================================================================
module rtcp_tuner_status_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rtsp_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rtsp_pkg::t_out_word o_out_data
);
    import rtsp_pkg::*;

    // Input register.
    logic       r_in_valid;
    t_in_word   r_in_data;

    // Packet walking state.
    logic [17:0] r_offset, n_offset;
    logic [15:0] r_words, n_words;
    logic [7:0]  r_kind, n_kind;
    logic [15:0] r_text_len, n_text_len;
    logic [15:0] r_text_cnt, n_text_cnt;

    // Text parser state.
    t_parse      r_parse, n_parse;

    // Result register.
    logic        r_out_valid;
    t_out_word   r_out_data;

    logic        advance;
    logic        accept;
    logic        string_end;
    logic        feed;
    logic        clear;
    logic        at_end;
    logic        is_app;
    logic [7:0]  b;
    logic        last;
    logic [15:0] cnt_inc;
    t_out_word   result;

    assign b    = r_in_data.data_byte;
    assign last = r_in_data.last_byte;

    // Header fields are taken as they stream past, so the byte that sets the
    // length already sees it for the end-of-packet check.
    always_comb begin
        n_kind     = r_kind;
        n_words    = r_words;
        n_text_len = r_text_len;
        n_text_cnt = r_text_cnt;
        feed       = 1'b0;
        clear      = 1'b0;
        string_end = 1'b0;
        cnt_inc    = r_text_cnt + 16'd1;

        if (r_offset == 18'd0) begin
            n_kind     = 8'd0;
            n_words    = 16'd0;
            n_text_len = 16'd0;
        end
        if (r_offset == 18'd1) begin
            n_kind = b;
        end
        if (r_offset == 18'd2) begin
            n_words = {b, 8'd0};
        end
        if (r_offset == 18'd3) begin
            n_words = {r_words[15:8], b};
        end

        at_end = (r_offset >= 18'd3) && (r_offset == {n_words, 2'b11});
        is_app = (n_kind == APP_TYPE) && (n_words > 16'd1);

        if (is_app) begin
            if (r_offset == 18'd14) begin
                n_text_len = {b, 8'd0};
            end else if (r_offset == 18'd15) begin
                n_text_len = {n_text_len[15:8], b};
                n_text_cnt = 16'd0;
                clear      = 1'b1;
                string_end = (n_text_len != 16'd0) && (at_end || last);
            end else if (r_offset >= 18'd16 && n_text_len != 16'd0) begin
                feed       = 1'b1;
                n_text_cnt = cnt_inc;
                string_end = (cnt_inc == n_text_len) || at_end || last;
            end
        end

        if (string_end) begin
            n_text_len = 16'd0;
        end

        if (last) begin
            n_offset   = 18'd0;
            n_words    = 16'd0;
            n_kind     = 8'd0;
            n_text_len = 16'd0;
            n_text_cnt = 16'd0;
        end else if (at_end) begin
            n_offset = 18'd0;
        end else begin
            n_offset = r_offset + 18'd1;
        end
    end

    rtsp_text_parser u_text_parser (
        .i_state  (r_parse),
        .i_char   (b),
        .i_feed   (feed),
        .i_clear  (clear),
        .o_state  (n_parse),
        .o_result (result)
    );

    // The held byte moves on unless it closes a string while the result
    // register is full and stalled.
    assign advance    = r_in_valid && (!string_end || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_offset    <= 18'd0;
            r_words     <= 16'd0;
            r_kind      <= 8'd0;
            r_text_len  <= 16'd0;
            r_text_cnt  <= 16'd0;
            r_parse     <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_offset   <= n_offset;
                r_words    <= n_words;
                r_kind     <= n_kind;
                r_text_len <= n_text_len;
                r_text_cnt <= n_text_cnt;
                r_parse    <= n_parse;
            end

            if (advance && string_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_data <= i_in_data;
        end
        if (advance && string_end) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### verif/rtcp_tuner_status_parser_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// RTCP tuner status parser testbench
// Feeds RTCP compound datagrams byte by byte and checks every status word
// against a cycle-free predictor that walks the same packets in parallel.
// ============================================================================
module rtcp_tuner_status_parser_tb;
    import rtsp_pkg::*;

    // The random part keeps going until the byte goal is met.
    localparam int WORD_GOAL     = 1900;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PERCENT  = 34;
    // Margin waited after every expected word has come out, so that anything
    // still in flight has time to show up.
    localparam int SETTLE_CYCLES = 16;

    // RTCP packet types used besides APP.
    localparam logic [7:0] SR_TYPE   = 8'd200;
    localparam logic [7:0] RR_TYPE   = 8'd201;
    localparam logic [7:0] SDES_TYPE = 8'd202;

    // ------------------------------------------------------------------------
    // Status predictor and scoreboard. It tracks the packet walk and the text
    // parse of the block, queues one expected status word whenever a string
    // closes, and compares the words the block delivers against that queue.
    // ------------------------------------------------------------------------
    class tuner_status_board;
        localparam bit [1:0] FIELD_LEVEL   = 2'd0;
        localparam bit [1:0] FIELD_LOCK    = 2'd1;
        localparam bit [1:0] FIELD_QUALITY = 2'd2;

        t_out_word   pending_status[$];
        int          errors = 0;
        int          reports = 0;
        int          tag_reports = 0;
        int          locked_reports = 0;
        string       tuner_tag = ";tuner=";

        // Packet walk.
        bit [17:0]   byte_pos;
        bit [15:0]   length_words;
        bit [7:0]    kind;
        bit [15:0]   text_len;
        bit [15:0]   text_seen;
        // Text parse.
        bit [2:0]    tag_hits;
        bit [2:0]    phase;
        bit [1:0]    field;
        bit [15:0]   magnitude;
        bit          minus;
        bit          has_digit;
        bit [15:0]   level;
        bit          lock;
        bit [15:0]   quality;

        // Stores the number just finished into its field. A negative level
        // or quality is kept as zero, while lock only cares about the digits.
        function void commit_value();
            bit [15:0] kept;
            kept = minus ? 16'd0 : magnitude;
            case (field)
                FIELD_LEVEL:   level = kept;
                FIELD_LOCK:    lock = (magnitude != 16'd0);
                FIELD_QUALITY: quality = kept;
                default: ;
            endcase
            field++;
            magnitude = '0;
            minus = 1'b0;
            has_digit = 1'b0;
        endfunction

        function void note_byte(t_in_word w);
            bit [7:0]  c;
            int        pos;
            int        grown;
            int        prod;
            bit        at_end;
            bit        is_app;
            bit        closes;
            t_out_word status;
            c = w.data_byte;
            pos = byte_pos;
            closes = 1'b0;

            if (pos == 0) begin
                kind = '0;
                length_words = '0;
                text_len = '0;
            end
            if (pos == 1) kind = c;
            if (pos == 2) length_words = {c, 8'h00};
            if (pos == 3) length_words[7:0] = c;

            at_end = pos >= 3 && pos == int'(length_words) * 4 + 3;
            is_app = kind == APP_TYPE && length_words > 16'd1;

            if (is_app) begin
                if (pos == 14) begin
                    text_len = {c, 8'h00};
                end else if (pos == 15) begin
                    text_len[7:0] = c;
                    text_seen = '0;
                    tag_hits = '0;
                    phase = PH_TAG;
                    field = FIELD_LEVEL;
                    magnitude = '0;
                    minus = 1'b0;
                    has_digit = 1'b0;
                    level = '0;
                    lock = 1'b0;
                    quality = '0;
                    closes = text_len != 16'd0 && (at_end || w.last_byte);
                end else if (pos >= 16 && text_len != 16'd0) begin
                    if (phase < PH_DONE) begin
                        if (c == 8'h00) begin
                            if (phase == PH_NUM && has_digit) commit_value();
                            phase = PH_DONE;
                        end else begin
                            case (phase)
                                PH_TAG: begin
                                    if (c == tuner_tag[tag_hits]) begin
                                        if (tag_hits == 3'd6) begin
                                            tag_hits = '0;
                                            phase = PH_COMMA;
                                        end else begin
                                            tag_hits++;
                                        end
                                    end else begin
                                        tag_hits = (c == ";") ? 3'd1 : 3'd0;
                                    end
                                end
                                PH_COMMA: begin
                                    if (c == ",") begin
                                        phase = PH_VSTART;
                                        field = FIELD_LEVEL;
                                    end
                                end
                                PH_VSTART: begin
                                    magnitude = '0;
                                    minus = 1'b0;
                                    has_digit = 1'b0;
                                    if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
                                        // whitespace before a value is skipped
                                    end else if (c == "+" || c == "-") begin
                                        minus = (c == "-");
                                        phase = PH_NUM;
                                    end else if (c >= "0" && c <= "9") begin
                                        magnitude = c - "0";
                                        has_digit = 1'b1;
                                        phase = PH_NUM;
                                    end else begin
                                        phase = PH_DONE;
                                    end
                                end
                                default: begin
                                    if (c >= "0" && c <= "9") begin
                                        grown = magnitude * 10 + c - "0";
                                        magnitude = (grown > SAT16) ? SAT16 : grown[15:0];
                                        has_digit = 1'b1;
                                    end else if (!has_digit) begin
                                        phase = PH_DONE;
                                    end else begin
                                        commit_value();
                                        phase = (c == "," && field < 2'd3) ? PH_VSTART
                                                                            : PH_DONE;
                                    end
                                end
                            endcase
                        end
                    end
                    text_seen++;
                    closes = text_seen == text_len || at_end || w.last_byte;
                end
            end

            if (closes) begin
                if (phase == PH_NUM && has_digit) commit_value();
                prod = level * 257;
                status.signal_strength = (prod > SAT16) ? SAT16 : prod[15:0];
                status.locked = lock;
                prod = lock ? quality * 4369 : 0;
                status.signal_quality = (prod > SAT16) ? SAT16 : prod[15:0];
                status.tuner_found = phase == PH_VSTART || phase == PH_NUM ||
                                     (phase == PH_DONE && field != FIELD_LEVEL);
                pending_status.push_back(status);
                text_len = '0;
                reports++;
                tag_reports += status.tuner_found;
                locked_reports += status.locked;
            end

            if (w.last_byte) begin
                byte_pos = '0;
                length_words = '0;
                kind = '0;
                text_len = '0;
                text_seen = '0;
            end else if (at_end) begin
                byte_pos = '0;
            end else begin
                byte_pos = pos + 1;
            end
        endfunction

        function void check_status(t_out_word got);
            t_out_word want;
            if (pending_status.size() == 0) begin
                $error("status word with nothing expected: %s %0d %s %0d %s %0d %s %0d",
                       "strength", got.signal_strength, "locked", got.locked,
                       "quality", got.signal_quality, "found", got.tuner_found);
                errors++;
                return;
            end
            want = pending_status.pop_front();
            if (got.signal_strength !== want.signal_strength) begin
                $error("signal_strength: expected %0d, got %0d",
                       want.signal_strength, got.signal_strength);
                errors++;
            end
            if (got.locked !== want.locked) begin
                $error("locked: expected %0d, got %0d", want.locked, got.locked);
                errors++;
            end
            if (got.signal_quality !== want.signal_quality) begin
                $error("signal_quality: expected %0d, got %0d",
                       want.signal_quality, got.signal_quality);
                errors++;
            end
            if (got.tuner_found !== want.tuner_found) begin
                $error("tuner_found: expected %0d, got %0d", want.tuner_found, got.tuner_found);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself.
    // ------------------------------------------------------------------------
    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_data;

    tuner_status_board board;
    logic [7:0] text_q[$];   // status text under construction
    logic [7:0] gram_q[$];   // datagram under construction
    bit         quiet = 1'b0;  // when set, neither side idles
    int         words_sent = 0;
    int         datagrams = 0;
    int         cycles = 0;

    always #5 i_clk = ~i_clk;

    rtcp_tuner_status_parser uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // Guard against a hang: a block that stops delivering never gets to the
    // end of the main sequence.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The receiving side stalls at random, except during the quiet stretch.
    // Stall changes at the falling edge so the block sees it settled.
    always @(negedge i_clk) begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
    end

    // A result word is taken at a rising edge with valid high and stall low.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) board.check_status(out_data);
    end

    // ------------------------------------------------------------------------
    // Sending side.
    // ------------------------------------------------------------------------

    // Offers one word, possibly after some idle cycles, and holds it until
    // the block accepts it. The predictor sees the word at that same edge.
    task automatic send_word(t_in_word w);
        bit placed = 1'b0;
        while (!placed) begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
                in_valid <= 1'b0;
            end else begin
                in_valid <= 1'b1;
                in_data <= w;
                placed = 1'b1;
            end
        end
        do @(posedge i_clk); while (in_stall);
        board.note_byte(w);
        words_sent++;
    endtask

    // Sends the datagram built so far; its final byte carries last_byte.
    task automatic send_datagram();
        t_in_word w;
        for (int i = 0; i < gram_q.size(); i++) begin
            w.data_byte = gram_q[i];
            w.last_byte = (i == gram_q.size() - 1);
            send_word(w);
        end
        gram_q.delete();
        datagrams++;
    endtask

    // Stops offering words until every expected status word has come out.
    task automatic wait_drained();
        @(negedge i_clk) in_valid <= 1'b0;
        while (board.pending_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Datagram construction.
    // ------------------------------------------------------------------------
    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    // One decimal value in one of the shapes the parser has to handle: small,
    // full range, saturating, signed, padded with whitespace, or no digits.
    function automatic void put_number();
        case ($urandom_range(9))
            0, 1: put_text($sformatf("%0d", $urandom_range(15)));
            2: put_text($sformatf("%0d", $urandom_range(255)));
            3: put_text($sformatf("%0d", $urandom_range(70000)));
            4: put_text($sformatf("-%0d", $urandom_range(300)));
            5: put_text($sformatf("+%0d", $urandom_range(20)));
            6: put_text("-0");
            7: begin
                text_q.push_back(8'd9);
                put_text($sformatf("  %0d", $urandom_range(15)));
            end
            8: put_text($sformatf("%0d%0d", $urandom, $urandom_range(999)));
            default: if ($urandom_range(1)) put_text("-");
        endcase
    endfunction

    // Builds a status text. Most are well formed with random values; the
    // rest have a damaged tag, a missing comma, odd separators, stray NUL or
    // high bytes, or are plain noise.
    function automatic void make_status();
        int pick;
        int at;
        text_q.delete();
        pick = $urandom_range(99);
        if (pick < 10) begin
            repeat ($urandom_range(24)) text_q.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(1)) put_text("ver=1.0;src=1");
        if (pick < 75) put_text(";tuner=");
        else if (pick < 85) put_text(";tun;tuner=");
        else if (pick < 92) put_text(";tuner");
        else put_text("tuner=");
        if ($urandom_range(9) != 0) put_text($sformatf("%0d", $urandom_range(1, 8)));
        if ($urandom_range(19) != 0) put_text(",");
        for (int k = 0; k < 3; k++) begin
            put_number();
            case ($urandom_range(11))
                0: put_text(";");
                1: put_text(" ");
                2: ;
                default: put_text(",");
            endcase
        end
        if ($urandom_range(2) == 0) put_text("dvbs2,11494.00,h,22000;pids=0,17");
        if ($urandom_range(7) == 0) begin
            at = $urandom_range(text_q.size() - 1);
            text_q.insert(at, $urandom_range(1) ? 8'h00 : 8'($urandom_range(128, 255)));
        end
    endfunction

    // Appends an APP packet carrying text_q. The string length field is
    // given separately so it can disagree with the text; spare words are
    // extra padding at the end of the packet.
    function automatic void put_app(int len_field, int spare_words);
        int total;
        int words;
        total = ((16 + text_q.size() + 3) / 4 + spare_words) * 4;
        words = total / 4 - 1;
        gram_q.push_back(8'h80 | 8'($urandom_range(31)));
        gram_q.push_back(APP_TYPE);
        gram_q.push_back(words[15:8]);
        gram_q.push_back(words[7:0]);
        repeat (10) gram_q.push_back(8'($urandom));
        gram_q.push_back(len_field[15:8]);
        gram_q.push_back(len_field[7:0]);
        foreach (text_q[i]) gram_q.push_back(text_q[i]);
        repeat (total - 16 - text_q.size()) gram_q.push_back(8'($urandom));
    endfunction

    // Appends a packet of any type with a random body.
    function automatic void put_other(logic [7:0] kind, int words);
        gram_q.push_back(8'h80 | 8'($urandom_range(31)));
        gram_q.push_back(kind);
        gram_q.push_back(words[15:8]);
        gram_q.push_back(words[7:0]);
        repeat (4 * words) gram_q.push_back(8'($urandom));
    endfunction

    task automatic send_status(string s);
        text_q.delete();
        put_text(s);
        put_app(text_q.size(), 0);
        send_datagram();
    endtask

    // A random compound datagram: mostly APP packets with status text, mixed
    // with reports, short APP packets and packets of arbitrary type. Some are
    // cut short and a few are nothing but line noise.
    task automatic random_datagram();
        int len_field;
        int spare;
        int cut;
        if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(1, 40)) gram_q.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(9))
                    0: put_other($urandom_range(1) ? SR_TYPE : RR_TYPE, $urandom_range(6));
                    1: put_other($urandom_range(1) ? SDES_TYPE : 8'($urandom),
                                 $urandom_range(4));
                    2: put_other(APP_TYPE, $urandom_range(4));
                    default: begin
                        make_status();
                        case ($urandom_range(9))
                            0: len_field = 0;
                            1: len_field = $urandom_range(1, text_q.size() + 1);
                            2: len_field = text_q.size() + $urandom_range(1, 8);
                            3: len_field = $urandom_range(65535);
                            default: len_field = text_q.size();
                        endcase
                        spare = ($urandom_range(4) == 0) ? $urandom_range(1, 2) : 0;
                        put_app(len_field, spare);
                    end
                endcase
            end
            if ($urandom_range(9) == 0) begin
                cut = $urandom_range(1, gram_q.size());
                while (gram_q.size() > cut) void'(gram_q.pop_back());
            end
        end
        send_datagram();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        board = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Full-scale values, then a negative level with the tuner unlocked.
        send_status(";tuner=1,255,1,15");
        send_status("ver=1.0;src=1;tuner=2,-7,0,9,dvbs2");
        // Magnitudes far beyond 16 bits saturate before scaling.
        send_status(";tuner=1,123456789,1,99999");
        // A negative zero counts as zero everywhere, lock included.
        send_status(";tuner=1,-0,-0,-0");
        // Tag restart after a partial match, whitespace, a plus sign, and a
        // quality with no digits.
        send_status(";tun;tuner=3, \t+12,1,x");
        // Tag without the comma after it, and text with no tag at all.
        send_status(";tuner=4");
        send_status("ver=1.0;src=1");

        // A NUL byte stops the parse; the word still comes at the string end.
        text_q.delete();
        put_text(";tuner=1,200,1");
        text_q.push_back(8'h00);
        put_text(",5");
        text_q.push_back(8'hff);
        put_app(text_q.size(), 0);
        send_datagram();

        // An APP packet too short to hold a string, followed by one that
        // ends right after a nonzero string length: an empty string.
        put_other(APP_TYPE, 1);
        text_q.delete();
        put_app(9, 0);
        send_datagram();

        // A string length that runs past the packet end, then a datagram
        // that ends in the middle of a string.
        put_other(SR_TYPE, 6);
        text_q.delete();
        put_text(";tuner=1,50,1,3");
        put_app(200, 0);
        text_q.delete();
        put_text(";tuner=1,60,1,4,tail");
        put_app(text_q.size(), 0);
        repeat (6) void'(gram_q.pop_back());
        send_datagram();

        // A string length shorter than the text cuts it after the level.
        text_q.delete();
        put_text(";tuner=1,99,1,7");
        put_app(12, 0);
        send_datagram();

        wait_drained();

        // Random traffic. A stretch of datagrams runs with no idling on
        // either side, and every so often the sender waits for the block to
        // empty out completely.
        while (words_sent < WORD_GOAL) begin
            quiet = (datagrams >= 14 && datagrams < 22);
            random_datagram();
            if (datagrams % 10 == 0) wait_drained();
        end
        quiet = 1'b0;
        wait_drained();

        $display("Run covered %0d datagrams and %0d bytes, %0d status words checked",
                 datagrams, words_sent, board.reports);
        $display("of which %0d carried a tuner tag and %0d reported lock",
                 board.tag_reports, board.locked_reports);
        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

### sim.f
src/rtsp_pkg.sv
src/rtsp_text_parser.sv
src/rtcp_tuner_status_parser.sv
verif/rtcp_tuner_status_parser_tb.sv
